@@ rtl/core/fds_pkg.sv @@
// ----------------------------------------------------------------------------
// fds_pkg - shared types and constants for the four-digit display scanner
// Item formats, command codes, symbol codes and queue depths.
// ----------------------------------------------------------------------------
package fds_pkg;

  localparam int NUM_DIGITS  = 4;
  localparam int SCAN_MS_DEF = 2;
  localparam int CMDQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH  = 2;

  // symbol codes
  localparam logic [3:0] SYM_DASH  = 4'd10;
  localparam logic [3:0] SYM_BLANK = 4'd11;

  // range limits
  localparam logic signed [19:0] NUM_MIN = -20'sd999;
  localparam logic signed [19:0] NUM_MAX = 20'sd9999;
  localparam logic [7:0]         MIN_MAX = 8'd99;
  localparam logic [7:0]         SEC_MAX = 8'd59;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_TIME   = 2'd2,
    MODE_STOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_NUMBER,
    OP_TIME,
    OP_DASH,
    OP_STOP
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIN
  } back_state_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [19:0] number_value;
    logic [2:0]         decimal_places;
    logic [7:0]         minute_count;
    logic [7:0]         second_count;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] lit_digit;
    logic [3:0] symbol_code;
    logic       dot_on;
    logic       all_dark;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_op_t     op;
    logic        neg;
    logic [1:0]  dec;
    logic [13:0] mag;
    logic [6:0]  minute;
    logic [5:0]  second;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic       dot;
    logic [3:0] sym;
  } glyph_t;

endpackage

@@ rtl/core/fds_front.sv @@
// ----------------------------------------------------------------------------
// fds_front - input classification and command queue
// Range-checks each item, folds bad values into a dash fill, and queues it.
// ----------------------------------------------------------------------------
module fds_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  fds_pkg::in_item_t  in_data,
  output logic               cmd_valid,
  output fds_pkg::cmd_t      cmd,
  input  logic               cmd_take
);

  localparam int Depth = fds_pkg::CMDQ_DEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  fds_pkg::cmd_t q_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr_en;
  fds_pkg::cmd_t cmd_new;
  logic [19:0]   abs_val;
  logic          neg;

  assign full      = (cnt_r == CW'(Depth));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;

  assign neg     = in_data.number_value < 20'sd0;
  assign abs_val = neg ? 20'(-in_data.number_value) : 20'(in_data.number_value);

  always_comb begin
    cmd_new        = '0;
    cmd_new.now_ms = in_data.now_ms;
    cmd_new.op     = fds_pkg::OP_TICK;
    case (in_data.mode)
      fds_pkg::MODE_TICK: begin
        cmd_new.op = fds_pkg::OP_TICK;
      end
      fds_pkg::MODE_NUMBER: begin
        if (in_data.number_value < fds_pkg::NUM_MIN ||
            in_data.number_value > fds_pkg::NUM_MAX ||
            in_data.decimal_places[2]) begin
          cmd_new.op = fds_pkg::OP_DASH;
        end else begin
          cmd_new.op  = fds_pkg::OP_NUMBER;
          cmd_new.neg = neg;
          cmd_new.dec = in_data.decimal_places[1:0];
          cmd_new.mag = abs_val[13:0];
        end
      end
      fds_pkg::MODE_TIME: begin
        if (in_data.minute_count > fds_pkg::MIN_MAX ||
            in_data.second_count > fds_pkg::SEC_MAX) begin
          cmd_new.op = fds_pkg::OP_DASH;
        end else begin
          cmd_new.op     = fds_pkg::OP_TIME;
          cmd_new.minute = in_data.minute_count[6:0];
          cmd_new.second = in_data.second_count[5:0];
        end
      end
      fds_pkg::MODE_STOP: begin
        cmd_new.op = fds_pkg::OP_STOP;
      end
      default: begin
        cmd_new.op = fds_pkg::OP_TICK;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_take) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !cmd_take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && cmd_take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

@@ rtl/core/fds_back.sv @@
// ----------------------------------------------------------------------------
// fds_back - command execution
// Holds the glyphs and scan state; converts numbers one digit per cycle.
// ----------------------------------------------------------------------------
module fds_back #(
  parameter int SCAN_MS = fds_pkg::SCAN_MS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  fds_pkg::cmd_t       cmd,
  output logic                cmd_take,
  input  logic                res_full,
  output logic                res_push,
  output fds_pkg::out_item_t  res
);

  localparam logic [15:0] Recip10 = 16'd52429;  // 2^19 / 10, rounded up
  localparam logic [7:0]  Recip10s = 8'd205;    // 2^11 / 10, rounded up

  fds_pkg::back_state_t state_r, state_nxt;
  fds_pkg::glyph_t glyph_r [fds_pkg::NUM_DIGITS];
  fds_pkg::glyph_t glyph_nxt [fds_pkg::NUM_DIGITS];
  logic [1:0]  digit_r, digit_nxt;
  logic        first_r, first_nxt;
  logic [31:0] switch_r, switch_nxt;
  logic [13:0] mag_r, mag_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  dec_r, dec_nxt;
  logic        neg_r, neg_nxt;

  logic [29:0] prod;
  logic [9:0]  quot;
  logic [13:0] quot10;
  logic [3:0]  rem;
  logic [2:0]  written;
  logic [31:0] elapsed;
  logic [1:0]  next_digit;
  logic [14:0] min_prod, sec_prod;
  logic [3:0]  min_tens, sec_tens;
  logic [6:0]  min_t10, sec_t10;

  // number digit: divide by ten through the reciprocal
  assign prod    = {16'b0, mag_r} * {14'b0, Recip10};
  assign quot    = prod[28:19];
  assign quot10  = 14'({quot, 3'b0}) + 14'({quot, 1'b0});
  assign rem     = 4'(mag_r - quot10);
  assign written = 3'd4 - {1'b0, pos_r};

  // time digits: values below 100
  assign min_prod = {8'b0, cmd.minute} * {7'b0, Recip10s};
  assign sec_prod = {9'b0, cmd.second} * {7'b0, Recip10s};
  assign min_tens = min_prod[14:11];
  assign sec_tens = sec_prod[14:11];
  assign min_t10  = 7'({min_tens, 3'b0}) + 7'({min_tens, 1'b0});
  assign sec_t10  = 7'({sec_tens, 3'b0}) + 7'({sec_tens, 1'b0});

  assign elapsed    = cmd.now_ms - switch_r;
  assign next_digit = digit_r + 2'd1;

  always_comb begin
    state_nxt  = state_r;
    digit_nxt  = digit_r;
    first_nxt  = first_r;
    switch_nxt = switch_r;
    mag_nxt    = mag_r;
    pos_nxt    = pos_r;
    dec_nxt    = dec_r;
    neg_nxt    = neg_r;
    for (int i = 0; i < fds_pkg::NUM_DIGITS; i++) begin
      glyph_nxt[i] = glyph_r[i];
    end
    cmd_take = 1'b0;
    res_push = 1'b0;
    res      = '0;

    case (state_r)
      fds_pkg::ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_take = 1'b1;
          case (cmd.op)
            fds_pkg::OP_TICK: begin
              if (first_r || elapsed >= 32'(SCAN_MS)) begin
                first_nxt   = 1'b0;
                switch_nxt  = cmd.now_ms;
                digit_nxt   = next_digit;
                res_push    = 1'b1;
                res.lit_digit   = next_digit;
                res.symbol_code = glyph_r[next_digit].sym;
                res.dot_on      = glyph_r[next_digit].dot;
                res.all_dark    = 1'b0;
              end
            end
            fds_pkg::OP_NUMBER: begin
              for (int i = 0; i < fds_pkg::NUM_DIGITS; i++) begin
                glyph_nxt[i] = '{dot: 1'b0, sym: fds_pkg::SYM_BLANK};
              end
              mag_nxt   = cmd.mag;
              dec_nxt   = cmd.dec;
              neg_nxt   = cmd.neg;
              pos_nxt   = 2'd3;
              state_nxt = fds_pkg::ST_CONV;
            end
            fds_pkg::OP_TIME: begin
              glyph_nxt[0] = '{dot: 1'b0, sym: min_tens};
              glyph_nxt[1] = '{dot: 1'b1, sym: 4'(cmd.minute - min_t10)};
              glyph_nxt[2] = '{dot: 1'b0, sym: sec_tens};
              glyph_nxt[3] = '{dot: 1'b0, sym: 4'({1'b0, cmd.second} - sec_t10)};
            end
            fds_pkg::OP_DASH: begin
              for (int i = 0; i < fds_pkg::NUM_DIGITS; i++) begin
                glyph_nxt[i] = '{dot: 1'b0, sym: fds_pkg::SYM_DASH};
              end
            end
            fds_pkg::OP_STOP: begin
              for (int i = 0; i < fds_pkg::NUM_DIGITS; i++) begin
                glyph_nxt[i] = '{dot: 1'b0, sym: fds_pkg::SYM_BLANK};
              end
              res_push        = 1'b1;
              res.lit_digit   = digit_r;
              res.symbol_code = fds_pkg::SYM_BLANK;
              res.dot_on      = 1'b0;
              res.all_dark    = 1'b1;
            end
            default: begin
              cmd_take = 1'b1;
            end
          endcase
        end
      end
      fds_pkg::ST_CONV: begin
        glyph_nxt[pos_r] = '{dot: 1'b0, sym: rem};
        mag_nxt = 14'(quot);
        // keep going while digits remain or zero padding is still owed
        if (pos_r != 2'd0 && (quot != '0 || written <= {1'b0, dec_r})) begin
          pos_nxt = pos_r - 2'd1;
        end else begin
          state_nxt = fds_pkg::ST_FIN;
        end
      end
      fds_pkg::ST_FIN: begin
        if (dec_r != 2'd0) begin
          glyph_nxt[2'd3 - dec_r].dot = 1'b1;
        end
        if (neg_r) begin
          if (pos_r == 2'd0) begin
            for (int i = 0; i < fds_pkg::NUM_DIGITS; i++) begin
              glyph_nxt[i] = '{dot: 1'b0, sym: fds_pkg::SYM_DASH};
            end
          end else begin
            glyph_nxt[pos_r - 2'd1] = '{dot: 1'b0, sym: fds_pkg::SYM_DASH};
          end
        end
        state_nxt = fds_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fds_pkg::ST_IDLE;
      digit_r  <= 2'd3;
      first_r  <= 1'b1;
      switch_r <= '0;
      for (int i = 0; i < fds_pkg::NUM_DIGITS; i++) begin
        glyph_r[i] <= '{dot: 1'b0, sym: fds_pkg::SYM_BLANK};
      end
    end else begin
      state_r  <= state_nxt;
      digit_r  <= digit_nxt;
      first_r  <= first_nxt;
      switch_r <= switch_nxt;
      for (int i = 0; i < fds_pkg::NUM_DIGITS; i++) begin
        glyph_r[i] <= glyph_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    pos_r <= pos_nxt;
    dec_r <= dec_nxt;
    neg_r <= neg_nxt;
  end

endmodule

@@ rtl/core/fds_outq.sv @@
// ----------------------------------------------------------------------------
// fds_outq - result queue
// Holds finished items until the receiver pops them.
// ----------------------------------------------------------------------------
module fds_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  fds_pkg::out_item_t  res,
  output logic                res_full,
  output logic                empty,
  input  logic                pop,
  output fds_pkg::out_item_t  out_data
);

  localparam int Depth = fds_pkg::OUTQ_DEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  fds_pkg::out_item_t q_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr_en, rd_en;

  assign res_full = (cnt_r == CW'(Depth));
  assign empty    = (cnt_r == '0);
  assign out_data = q_r[rd_ptr_r];
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

@@ rtl/core/four_digit_display_scanner.sv @@
// ----------------------------------------------------------------------------
// four_digit_display_scanner - multiplexed four-digit display controller
// Keeps one glyph per digit and reports the digit to light on each scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input items go in through push/full: one is taken on a clock edge with
//   push high and full low. The mode field selects tick, show number, show
//   time or stop. Results come out through empty/pop: the oldest result sits
//   on out_data while empty is low and leaves on an edge with pop high.
//   Only a tick that scans and a stop produce a result.
// Processing:
//   With the back end idle, a tick or stop result is registered in the
//   command queue and then in the result queue before it shows on out_data.
//   Tick, stop, show time and out-of-range items finish in the idle state;
//   show number loads there, converts one digit per cycle through the
//   divide-by-ten reciprocal multiplier and ends in a finishing state.
//   A two-entry command queue lets items arrive while a number converts.
// Reset:
//   rst_n low clears both queues, blanks every glyph, sets the lit digit
//   to 3 so the first scan lights digit 0, and arms the first-scan flag.
// Stall:
//   When the result queue is full the back end waits; the command queue
//   then fills and full rises. No item is dropped.
// ----------------------------------------------------------------------------
module four_digit_display_scanner #(
  parameter int SCAN_MS = fds_pkg::SCAN_MS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  fds_pkg::in_item_t   in_data,
  output logic                empty,
  input  logic                pop,
  output fds_pkg::out_item_t  out_data
);

  fds_pkg::cmd_t      cmd;
  logic               cmd_valid;
  logic               cmd_take;
  logic               res_full;
  logic               res_push;
  fds_pkg::out_item_t res;

  // front end: range checks and command queue
  fds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back end: glyph store, scan state, number conversion
  fds_back #(
    .SCAN_MS (SCAN_MS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue decouples the receiver from the back end
  fds_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

@@ rtl/core/fds_checker.sv @@
// ----------------------------------------------------------------------------
// fds_checker - port-level checks for the display scanner
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module fds_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input fds_pkg::out_item_t  out_data
);

  // both queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not drained after reset");

  // a held result stays put until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while stalled");

  // a darkening result always shows a blank without a dot
  a_dark_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.all_dark) |->
      (out_data.symbol_code == fds_pkg::SYM_BLANK && !out_data.dot_on))
    else $error("dark result not blank");

  // only digit, dash or blank codes ever appear
  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.symbol_code <= fds_pkg::SYM_BLANK))
    else $error("symbol code out of range");

endmodule

bind four_digit_display_scanner fds_checker u_fds_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

@@ sim/four_digit_display_scanner_tb.sv @@
// ----------------------------------------------------------------------------
// four_digit_display_scanner_tb - self-checking bench for the display scanner
// Pushes show-number, show-time, tick and stop items through the input queue,
// predicts every scan and stop result in a scoreboard, and compares each
// popped result field by field. Both queue sides stall at random.
// ----------------------------------------------------------------------------
module four_digit_display_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fds_pkg::*;

  // Cycles with no item moving on either side before the run is declared hung.
  // Worst honest case is a long random sender gap plus a number conversion
  // and a receiver that idles 75 percent of the time; this is many times that.
  localparam int STALL_LIMIT  = 2000;
  // Settle time after the last expected result: a trailing tick or show item
  // produces nothing, but a number conversion may still be running.
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 200;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of the display state and the queue of results
  // that the accepted items are due to produce.
  // --------------------------------------------------------------------------
  class display_scoreboard;
    glyph_t      glyphs[NUM_DIGITS];
    logic [1:0]  lit_idx;
    bit          first_scan;
    logic [31:0] last_switch;
    out_item_t   scan_results_due[$];
    int          errors;

    function new();
      fill_glyphs(glyph_t'{dot: 1'b0, sym: SYM_BLANK});
      lit_idx     = 2'd3;
      first_scan  = 1'b1;
      last_switch = '0;
      errors      = 0;
    endfunction

    function void fill_glyphs(glyph_t g);
      foreach (glyphs[i]) glyphs[i] = g;
    endfunction

    // right-aligned decimal with zero padding, dot and leading minus
    function void render_number(logic signed [19:0] value, logic [2:0] places);
      int          num;
      int unsigned mag;
      int          pos;
      bit          neg;
      num = value;
      if (num < -999 || num > 9999 || places >= NUM_DIGITS) begin
        fill_glyphs(glyph_t'{dot: 1'b0, sym: SYM_DASH});
        return;
      end
      neg = (num < 0);
      mag = neg ? -num : num;
      fill_glyphs(glyph_t'{dot: 1'b0, sym: SYM_BLANK});
      pos = NUM_DIGITS;
      do begin
        pos--;
        glyphs[pos] = glyph_t'{dot: 1'b0, sym: 4'(mag % 10)};
        mag = mag / 10;
      end while (pos > 0 && (mag != 0 || NUM_DIGITS - pos <= places));
      if (places != 0) glyphs[NUM_DIGITS - 1 - places].dot = 1'b1;
      if (neg) begin
        // minus needs a free digit left of the number
        if (pos == 0) fill_glyphs(glyph_t'{dot: 1'b0, sym: SYM_DASH});
        else glyphs[pos - 1] = glyph_t'{dot: 1'b0, sym: SYM_DASH};
      end
    endfunction

    function void note_item(in_item_t it);
      logic [31:0] gap;
      case (it.mode)
        MODE_NUMBER: render_number(it.number_value, it.decimal_places);
        MODE_TIME: begin
          if (it.minute_count > MIN_MAX || it.second_count > SEC_MAX) begin
            fill_glyphs(glyph_t'{dot: 1'b0, sym: SYM_DASH});
          end else begin
            glyphs[0] = glyph_t'{dot: 1'b0, sym: 4'(it.minute_count / 10)};
            glyphs[1] = glyph_t'{dot: 1'b1, sym: 4'(it.minute_count % 10)};
            glyphs[2] = glyph_t'{dot: 1'b0, sym: 4'(it.second_count / 10)};
            glyphs[3] = glyph_t'{dot: 1'b0, sym: 4'(it.second_count % 10)};
          end
        end
        MODE_STOP: begin
          fill_glyphs(glyph_t'{dot: 1'b0, sym: SYM_BLANK});
          scan_results_due.push_back(out_item_t'{lit_digit: lit_idx, symbol_code: SYM_BLANK,
                                                 dot_on: 1'b0, all_dark: 1'b1});
        end
        default: begin
          gap = it.now_ms - last_switch;
          if (!first_scan && gap < 32'(SCAN_MS_DEF)) return;
          first_scan  = 1'b0;
          last_switch = it.now_ms;
          lit_idx     = lit_idx + 2'd1;
          scan_results_due.push_back(out_item_t'{lit_digit: lit_idx,
                                                 symbol_code: glyphs[lit_idx].sym,
                                                 dot_on: glyphs[lit_idx].dot,
                                                 all_dark: 1'b0});
        end
      endcase
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (scan_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = scan_results_due.pop_front();
      check_field("lit_digit", want.lit_digit, got.lit_digit);
      check_field("symbol_code", want.symbol_code, got.symbol_code);
      check_field("dot_on", want.dot_on, got.dot_on);
      check_field("all_dark", want.all_dark, got.all_dark);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup - every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  display_scoreboard board = new();

  // bench-side millisecond clock that tick items are stamped with
  logic [31:0] ms_now;
  int          items_sent    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  four_digit_display_scanner i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Item drivers
  // Inputs change by NBA at the rising edge; handshake signals are read
  // right after the edge, so they still hold the values the DUT sampled.
  // --------------------------------------------------------------------------

  // random content in every field, then the mode forced
  function automatic in_item_t noisy_item(mode_t m);
    logic [95:0] raw;
    in_item_t    it;
    raw     = {$urandom(), $urandom(), $urandom()};
    it      = raw[$bits(in_item_t)-1:0];
    it.mode = m;
    return it;
  endfunction

  // push stays high from one item to the next unless a gap is drawn,
  // so it only ever gets one NBA per edge
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push    <= 1'b0;
      in_data <= noisy_item(mode_t'($urandom_range(3)));
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic send_tick(input logic [31:0] now);
    in_item_t it;
    it        = noisy_item(MODE_TICK);
    it.now_ms = now;
    ms_now    = now;
    send_item(it);
  endtask

  task automatic send_number(input int value, input int places);
    in_item_t it;
    it                = noisy_item(MODE_NUMBER);
    it.number_value   = 20'(value);
    it.decimal_places = 3'(places);
    send_item(it);
  endtask

  task automatic send_time(input int minutes, input int seconds);
    in_item_t it;
    it              = noisy_item(MODE_TIME);
    it.minute_count = 8'(minutes);
    it.second_count = 8'(seconds);
    send_item(it);
  endtask

  // mostly legal ticks; a few too early, a few far jumps across the wrap
  task automatic random_tick();
    logic [31:0] step;
    case ($urandom_range(19))
      0:          step = $urandom();
      1, 2, 3, 4: step = $urandom_range(1);
      default:    step = $urandom_range(SCAN_MS_DEF + 2, SCAN_MS_DEF);
    endcase
    send_tick(ms_now + step);
  endtask

  // one display update: number, time or stop, mostly in range
  task automatic random_update();
    int value;
    int places;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        case ($urandom_range(5))
          0:       value = $urandom_range(9);
          1:       value = $urandom_range(99);
          2:       value = $urandom_range(9999);
          3:       value = -int'($urandom_range(999, 1));
          4:       value = $urandom_range(1) ? int'($urandom_range(10010, 9990))
                                             : -int'($urandom_range(1010, 990));
          default: value = $urandom();
        endcase
        places = ($urandom_range(4) == 0) ? $urandom_range(7, 4) : $urandom_range(3);
        send_number(value, places);
      end
      6, 7, 8: begin
        if ($urandom_range(7) == 0) send_time($urandom_range(255), $urandom_range(255));
        else send_time($urandom_range(99), $urandom_range(59));
      end
      default: send_item(noisy_item(MODE_STOP));
    endcase
  endtask

  // Random traffic. Much of it is an update followed by a full sweep of
  // well-spaced ticks, so every stored glyph is read back out.
  task automatic run_phase(input int s_idle, input int r_idle);
    int stop_at;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at       = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 30) begin
        random_update();
        repeat (NUM_DIGITS) send_tick(ms_now + SCAN_MS_DEF + $urandom_range(1));
      end else if ($urandom_range(9) < 6) begin
        random_tick();
      end else begin
        random_update();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop, check every popped item
  // --------------------------------------------------------------------------
  initial begin : result_sink
    wait (rst_n === 1'b1);
    forever begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (pop && !empty) board.check_result(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if neither side moves an item for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("four_digit_display_scanner_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 75;

    // Directed: first scan ignores the timer, a tick inside the scan time is
    // dropped, and the timer difference wraps through zero.
    send_tick(32'hFFFF_FFFE);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0000);
    // field extremes, both out of range
    send_number(524287, 7);
    send_tick(32'd2);
    send_number(-524288, 0);
    // negative fraction with a free digit for the minus: "-0.05"
    send_number(-5, 2);
    send_tick(32'd4);
    send_tick(32'd6);
    send_tick(32'd8);
    // minus with no digit left: all dashes
    send_number(-5, 3);
    send_tick(32'd10);
    // range edges and zero padding through the point
    send_number(9999, 0);
    send_number(-999, 0);
    send_number(10000, 0);
    send_number(-1000, 0);
    send_number(0, 3);
    // time edges and both kinds of overflow
    send_time(99, 59);
    send_time(255, 255);
    send_time(0, 60);
    send_time(100, 0);
    send_time(0, 0);
    send_tick(32'd12);
    send_item(noisy_item(MODE_STOP));
    send_tick(32'd13);

    run_phase(38, 75);
    run_phase(75, 38);
    run_phase(0, 0);
    push <= 1'b0;

    while (board.scan_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0) begin
      $display("four_digit_display_scanner_tb: done, clean");
    end else begin
      $display("four_digit_display_scanner_tb: done, errors");
    end
    $finish;
  end

endmodule
